### rtl/core/s5scan_pkg.sv
// Shared types and constants for the S5 sleep-type scanner.
// Used by every module under rtl/core; depends on nothing.

package s5scan_pkg;

  // One input word from the byte stream.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  // One result word, produced once per stream.
  typedef struct packed {
    logic       found;
    logic [2:0] sleep_type_a;
    logic [2:0] sleep_type_b;
  } result_t;

  // A stream byte with its integer-opcode class attached.
  typedef struct packed {
    logic [7:0] data;
    logic       int_ok;     // usable as the opcode of a package integer
    logic [3:0] int_extra;  // bytes after a prefix, zero for a bare constant
  } cbyte_t;

  // Classified word as it travels from front to back.
  typedef struct packed {
    cbyte_t b;
    logic   last;
  } cword_t;

  localparam logic [7:0] NAME_CHAR_0 = 8'h5F;  // '_'
  localparam logic [7:0] NAME_CHAR_1 = 8'h53;  // 'S'
  localparam logic [7:0] NAME_CHAR_2 = 8'h35;  // '5'
  localparam logic [7:0] NAME_CHAR_3 = 8'h5F;  // '_'
  localparam logic [7:0] PACKAGE_OP  = 8'h12;

  localparam logic [7:0] BYTE_PREFIX  = 8'h0A;
  localparam logic [7:0] WORD_PREFIX  = 8'h0B;
  localparam logic [7:0] DWORD_PREFIX = 8'h0C;
  localparam logic [7:0] QWORD_PREFIX = 8'h0E;
  localparam logic [7:0] CONST_MAX    = 8'h3F;
  localparam logic [2:0] TYPE_MASK    = 3'h7;

  localparam int FIFO_DEPTH = 4;

endpackage

### rtl/core/aml_s5_sleep_type_scanner.sv
// Scans an AML byte stream for the first "_S5_" package and reports its two
// sleep types once per stream. Bytes enter one per cycle while the queue is not
// full: a front end tags each byte with its integer-opcode class and pushes it
// into a four-word queue; the back end drains the queue into a WINDOW_BYTES
// window and checks the candidate at the oldest entry in the same cycle it
// would slide out, so one byte per cycle is sustained while scanning. The byte
// marked last starts a drain of the window, one start position per cycle; the
// result register is then loaded once the output side is free. While draining
// and reporting, new bytes collect in the queue until it fills. A result waits
// on the output side without stopping intake of the next stream.
// Depends on s5scan_pkg, s5scan_front, s5scan_fifo and s5scan_back.

module aml_s5_sleep_type_scanner #(
  parameter int WINDOW_BYTES = 28
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  s5scan_pkg::item_t    item,
  output logic                 empty,
  input  logic                 pop,
  output s5scan_pkg::result_t  result
);

  logic                 wr_en;
  s5scan_pkg::cword_t   wr_word;
  logic                 q_empty;
  logic                 q_take;
  s5scan_pkg::cword_t   q_word;

  s5scan_front u_front (
    .push      (push),
    .fifo_full (full),
    .item      (item),
    .wr_en     (wr_en),
    .wr_word   (wr_word)
  );

  s5scan_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_word),
    .full    (full),
    .rd_en   (q_take),
    .rd_data (q_word),
    .empty   (q_empty)
  );

  s5scan_back #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (!q_empty),
    .in_word  (q_word),
    .in_take  (q_take),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

### rtl/core/s5scan_front.sv
// Front end: accepts stream bytes and tags each with its integer-opcode class.
// Depends on s5scan_pkg; feeds s5scan_fifo.

module s5scan_front (
  input  logic                 push,
  input  logic                 fifo_full,
  input  s5scan_pkg::item_t    item,
  output logic                 wr_en,
  output s5scan_pkg::cword_t   wr_word
);

  always_comb begin
    wr_en             = push && !fifo_full;
    wr_word.last      = item.last_byte;
    wr_word.b.data    = item.data_byte;
    wr_word.b.int_ok  = 1'b1;
    wr_word.b.int_extra = 4'd0;
    unique case (item.data_byte)
      s5scan_pkg::BYTE_PREFIX:  wr_word.b.int_extra = 4'd1;
      s5scan_pkg::WORD_PREFIX:  wr_word.b.int_extra = 4'd2;
      s5scan_pkg::DWORD_PREFIX: wr_word.b.int_extra = 4'd4;
      s5scan_pkg::QWORD_PREFIX: wr_word.b.int_extra = 4'd8;
      default: begin
        // bare constant opcode, or nothing an integer may start with
        wr_word.b.int_ok = (item.data_byte <= s5scan_pkg::CONST_MAX);
      end
    endcase
  end

endmodule

### rtl/core/s5scan_fifo.sv
// Short queue between the classifying front end and the window back end.
// Depends on s5scan_pkg for the word type and depth.

module s5scan_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  s5scan_pkg::cword_t   wr_data,
  output logic                 full,
  input  logic                 rd_en,
  output s5scan_pkg::cword_t   rd_data,
  output logic                 empty
);

  localparam int PTR_W = $clog2(s5scan_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(s5scan_pkg::FIFO_DEPTH + 1);

  s5scan_pkg::cword_t mem [s5scan_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full    = (count == CNT_W'(s5scan_pkg::FIFO_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (!wr_en && rd_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### rtl/core/s5scan_back.sv
// Back end: byte window, candidate check at the oldest entry, end-of-stream
// drain and the result register. Depends on s5scan_pkg.

module s5scan_back #(
  parameter int WINDOW_BYTES = 28
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  s5scan_pkg::cword_t   in_word,
  output logic                 in_take,
  output logic                 empty,
  input  logic                 pop,
  output s5scan_pkg::result_t  result
);

  localparam int IDX_W  = $clog2(WINDOW_BYTES);
  localparam int FILL_W = $clog2(WINDOW_BYTES + 1);
  localparam int POS_W  = FILL_W + 1;

  typedef enum logic [1:0] {ST_RUN, ST_DRAIN, ST_REPORT} state_t;

  state_t                  state;
  s5scan_pkg::cbyte_t      win [WINDOW_BYTES];
  logic [FILL_W-1:0]       fill;
  logic                    match_seen;
  logic [2:0]              held_a;
  logic [2:0]              held_b;
  logic                    out_valid;
  s5scan_pkg::result_t     out_q;

  logic                    win_full;
  logic                    shift_push;
  logic                    judge_en;
  logic                    hit;
  logic                    out_free;

  // candidate check signals
  logic [POS_W-1:0]        av;
  logic [1:0]              more;
  logic [POS_W-1:0]        p1;
  logic [POS_W-1:0]        p2;
  s5scan_pkg::cbyte_t      op1;
  s5scan_pkg::cbyte_t      op2;
  logic [7:0]              v1;
  logic [7:0]              v2;
  logic [3:0]              off2;
  logic                    hdr_ok;
  logic                    len_ok;
  logic                    i1_ok;
  logic                    i2_ok;
  logic [2:0]              type_a;
  logic [2:0]              type_b;

  assign win_full   = (fill == FILL_W'(WINDOW_BYTES));
  assign in_take    = (state == ST_RUN) && in_valid;
  assign shift_push = in_take && win_full;
  assign judge_en   = ((state == ST_RUN) && win_full) || (state == ST_DRAIN);
  assign out_free   = !out_valid || pop;
  assign empty      = !out_valid;
  assign result     = out_q;

  // Judge the candidate that starts at the oldest entry against fill bytes.
  always_comb begin
    av   = POS_W'(fill);
    more = win[5].data[7:6];
    p1   = POS_W'(7) + POS_W'(more);
    op1  = win[7];
    v1   = win[8].data;
    for (int k = 0; k < 4; k++) begin
      if (more == 2'(k)) begin
        op1 = win[7 + k];
        v1  = win[8 + k].data;
      end
    end
    off2 = 4'(more) + op1.int_extra;
    p2   = p1 + POS_W'(1) + POS_W'(op1.int_extra);
    op2  = win[8];
    v2   = win[9].data;
    for (int k = 0; k < 12; k++) begin
      if (off2 == 4'(k)) begin
        op2 = win[8 + k];
        v2  = win[9 + k].data;
      end
    end

    hdr_ok = (av >= POS_W'(5)) &&
             (win[0].data == s5scan_pkg::NAME_CHAR_0) &&
             (win[1].data == s5scan_pkg::NAME_CHAR_1) &&
             (win[2].data == s5scan_pkg::NAME_CHAR_2) &&
             (win[3].data == s5scan_pkg::NAME_CHAR_3) &&
             (win[4].data == s5scan_pkg::PACKAGE_OP);
    // length bytes plus the element count must all be present
    len_ok = (POS_W'(6) + POS_W'(more)) < av;
    i1_ok  = op1.int_ok && ((p1 + POS_W'(op1.int_extra)) < av);
    i2_ok  = op2.int_ok && ((p2 + POS_W'(op2.int_extra)) < av);

    type_a = ((op1.int_extra == 4'd0) ? op1.data[2:0] : v1[2:0]) & s5scan_pkg::TYPE_MASK;
    type_b = ((op2.int_extra == 4'd0) ? op2.data[2:0] : v2[2:0]) & s5scan_pkg::TYPE_MASK;

    hit = judge_en && !match_seen && hdr_ok && len_ok && i1_ok && i2_ok;
  end

  // Window storage: append until full, then slide; drain slides out the rest.
  always_ff @(posedge clk) begin
    if (shift_push || (state == ST_DRAIN)) begin
      for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
        win[i] <= win[i + 1];
      end
      if (shift_push) begin
        win[WINDOW_BYTES - 1] <= in_word.b;
      end
    end else if (in_take) begin
      win[fill[IDX_W-1:0]] <= in_word.b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_RUN;
      fill       <= '0;
      match_seen <= 1'b0;
      held_a     <= '0;
      held_b     <= '0;
      out_valid  <= 1'b0;
      out_q      <= '0;
    end else begin
      if (pop) begin
        out_valid <= 1'b0;
      end
      if (hit) begin
        match_seen <= 1'b1;
        held_a     <= type_a;
        held_b     <= type_b;
      end
      unique case (state)
        ST_RUN: begin
          if (in_take) begin
            if (!win_full) begin
              fill <= fill + FILL_W'(1);
            end
            if (in_word.last) begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          // judge every remaining start, oldest first
          fill <= fill - FILL_W'(1);
          if (fill == FILL_W'(1)) begin
            state <= ST_REPORT;
          end
        end
        ST_REPORT: begin
          if (out_free) begin
            out_valid          <= 1'b1;
            out_q.found        <= match_seen;
            out_q.sleep_type_a <= match_seen ? held_a : 3'd0;
            out_q.sleep_type_b <= match_seen ? held_b : 3'd0;
            match_seen         <= 1'b0;
            held_a             <= '0;
            held_b             <= '0;
            state              <= ST_RUN;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

endmodule
